// ===== rtl/csp_pkg.sv =====
// Shared types and constants of the call stack profiler.
// Payload structs for both channels, command and status codes, table row layout.
// No dependencies.
`timescale 1ns / 1ps

package csp_pkg;

  // Command codes of an input transaction
  localparam logic [1:0] CMD_ENTRY = 2'd0;
  localparam logic [1:0] CMD_EXIT  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Status codes of a result transaction
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DISABLED  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX = 3'd5;

  // Minimum of a fresh entry: no call seen yet
  localparam logic [31:0] NONE_MIN = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] function_id;
    logic [31:0] timestamp;
    logic [7:0]  entry_index;
  } csp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [31:0] id_out;
    logic [31:0] call_count;
    logic [31:0] total_time;
    logic [31:0] net_time;
    logic [31:0] min_time;
    logic [31:0] max_time;
    logic [6:0]  depth;
    logic [8:0]  entries_used;
  } csp_out_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_ENTRY,
    OP_EXIT,
    OP_READ,
    OP_CLEAR,
    OP_OFF
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] function_id;
    logic [31:0] timestamp;
    logic [7:0]  entry_index;
  } csp_op_t;

  // One statistics table row
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] count;
    logic [31:0] total;
    logic [31:0] net;
    logic [31:0] min;
    logic [31:0] max;
  } csp_row_t;

endpackage

// ===== rtl/csp_front.sv =====
// Front end of the call stack profiler: enable register, command classification
// and a two-entry operation queue toward the back end. Depends on csp_pkg.
`timescale 1ns / 1ps

module csp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  csp_pkg::csp_in_t in_i,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  output logic             q_valid_o,
  output csp_pkg::csp_op_t q_item_o,
  input  logic             q_pop_i
);
  import csp_pkg::*;

  logic    enable_q;
  csp_op_t qmem_q [2];
  logic    wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic    accept;
  csp_op_t item;

  assign full      = (cnt_q == 2'd2);
  assign accept    = push && !full;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = qmem_q[rd_ptr_q];

  // Enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // Classify the command; entry and exit are ignored while disabled
  always_comb begin
    item.function_id = in_i.function_id;
    item.timestamp   = in_i.timestamp;
    item.entry_index = in_i.entry_index;
    unique case (in_i.cmd)
      CMD_ENTRY: item.op = enable_q ? OP_ENTRY : OP_OFF;
      CMD_EXIT:  item.op = enable_q ? OP_EXIT : OP_OFF;
      CMD_READ:  item.op = OP_READ;
      default:   item.op = OP_CLEAR;
    endcase
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qmem_q[wr_ptr_q] <= item;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, accept} - {1'b0, q_pop_i};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != 2'd0)
    else $error("pop from empty operation queue");
  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !q_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("accepted transaction not counted");

endmodule

// ===== rtl/csp_back.sv =====
// Back end of the call stack profiler: statistics table memory, frame stack memory,
// the sequencer that carries out each operation, and the result register. Depends on csp_pkg.
`timescale 1ns / 1ps

module csp_back #(
  parameter int TABLE_ENTRIES = 256,
  parameter int STACK_FRAMES  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  csp_pkg::csp_op_t  q_item_i,
  output logic              q_pop_o,
  output csp_pkg::csp_out_t res_o,
  output logic              res_valid_o,
  input  logic              res_pop_i
);
  import csp_pkg::*;

  localparam int TW = $clog2(TABLE_ENTRIES);
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int FW = $clog2(STACK_FRAMES);
  localparam int DW = $clog2(STACK_FRAMES + 1);
  localparam int CW = (UW > 8) ? UW : 8;

  typedef struct packed {
    logic [TW-1:0] slot;
    logic [31:0]   start;
    logic [31:0]   child;
  } frame_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_RD_RESP  = 7'b0000010,
    S_CMP      = 7'b0000100,
    S_ENT_UPD  = 7'b0001000,
    S_X_FRAME  = 7'b0010000,
    S_X_TABLE  = 7'b0100000,
    S_X_PARENT = 7'b1000000
  } state_e;

  // Memories
  csp_row_t tab_mem [TABLE_ENTRIES];
  frame_t   fr_mem  [STACK_FRAMES];
  csp_row_t tab_rd_q, tab_wdata, row_c;
  frame_t   fr_rd_q, fr_wdata;
  logic [TW-1:0] tab_addr, sl_c;
  logic [FW-1:0] fr_addr;
  logic     tab_re, tab_we, fr_re, fr_we;

  state_e   state_q, state_d;
  csp_op_t  cur_q, cur_d;
  logic [TW-1:0] scan_q, scan_d, slot_q, slot_d;
  logic     hit_q, hit_d;
  logic [UW-1:0] used_q, used_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [15:0] lost_q, lost_d, lost_inc;
  logic [31:0] elapsed_q, elapsed_d, own_q, own_d;
  logic     res_valid_q, res_load;
  csp_out_t res_q, res_body, res_next;

  assign lost_inc    = (lost_q == 16'hFFFF) ? lost_q : lost_q + 16'd1;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i && !res_valid_q;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  function automatic csp_out_t mk_out(logic [2:0] st, logic has, logic [7:0] sl,
                                      csp_row_t r);
    csp_out_t o;
    o = '0;
    o.status = st;
    if (has) begin
      o.slot       = sl;
      o.id_out     = r.id;
      o.call_count = r.count;
      o.total_time = r.total;
      o.net_time   = r.net;
      o.min_time   = r.min;
      o.max_time   = r.max;
    end
    return o;
  endfunction

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    scan_d    = scan_q;
    slot_d    = slot_q;
    hit_d     = hit_q;
    used_d    = used_q;
    depth_d   = depth_q;
    lost_d    = lost_q;
    elapsed_d = elapsed_q;
    own_d     = own_q;
    tab_re    = 1'b0;
    tab_we    = 1'b0;
    tab_addr  = '0;
    tab_wdata = tab_rd_q;
    fr_re     = 1'b0;
    fr_we     = 1'b0;
    fr_addr   = '0;
    fr_wdata  = fr_rd_q;
    res_load  = 1'b0;
    res_body  = '0;
    row_c     = tab_rd_q;
    sl_c      = slot_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          cur_d = q_item_i;
          case (q_item_i.op)
            OP_ENTRY: begin
              scan_d = '0;
              hit_d  = 1'b0;
              if (used_q == '0) begin
                state_d = S_ENT_UPD;
              end else begin
                tab_re   = 1'b1;
                tab_addr = '0;
                state_d  = S_CMP;
              end
            end
            OP_EXIT: begin
              if (lost_q != '0) begin
                lost_d   = lost_q - 16'd1;
                res_load = 1'b1;
                res_body = mk_out(ST_OVERFLOW, 1'b0, 8'd0, row_c);
              end else if (depth_q == '0) begin
                res_load = 1'b1;
                res_body = mk_out(ST_UNDERFLOW, 1'b0, 8'd0, row_c);
              end else begin
                fr_re   = 1'b1;
                fr_addr = FW'(depth_q - DW'(1));
                state_d = S_X_FRAME;
              end
            end
            OP_READ: begin
              if (CW'(q_item_i.entry_index) < CW'(used_q)) begin
                tab_re   = 1'b1;
                tab_addr = TW'(q_item_i.entry_index);
                slot_d   = TW'(q_item_i.entry_index);
                state_d  = S_RD_RESP;
              end else begin
                res_load = 1'b1;
                res_body = mk_out(ST_BAD_INDEX, 1'b0, 8'd0, row_c);
              end
            end
            OP_CLEAR: begin
              used_d   = '0;
              depth_d  = '0;
              lost_d   = '0;
              res_load = 1'b1;
              res_body = mk_out(ST_OK, 1'b0, 8'd0, row_c);
            end
            default: begin
              res_load = 1'b1;
              res_body = mk_out(ST_DISABLED, 1'b0, 8'd0, row_c);
            end
          endcase
        end
      end
      S_RD_RESP: begin
        res_load = 1'b1;
        res_body = mk_out(ST_OK, 1'b1, 8'(slot_q), tab_rd_q);
        state_d  = S_IDLE;
      end
      // One table entry compared per cycle; the next read is issued alongside
      S_CMP: begin
        if (tab_rd_q.id == cur_q.function_id) begin
          hit_d   = 1'b1;
          slot_d  = scan_q;
          state_d = S_ENT_UPD;
        end else if (UW'(scan_q) + UW'(1) == used_q) begin
          state_d = S_ENT_UPD;
        end else begin
          scan_d   = scan_q + TW'(1);
          tab_re   = 1'b1;
          tab_addr = scan_q + TW'(1);
        end
      end
      S_ENT_UPD: begin
        state_d = S_IDLE;
        if (!hit_q && used_q >= UW'(TABLE_ENTRIES)) begin
          lost_d   = lost_inc;
          res_load = 1'b1;
          res_body = mk_out(ST_FULL, 1'b0, 8'd0, row_c);
        end else begin
          if (!hit_q) begin
            sl_c      = TW'(used_q);
            used_d    = used_q + UW'(1);
            row_c     = '0;
            row_c.id  = cur_q.function_id;
            row_c.min = NONE_MIN;
          end
          row_c.count = row_c.count + 32'd1;
          tab_we      = 1'b1;
          tab_addr    = sl_c;
          tab_wdata   = row_c;
          res_load    = 1'b1;
          if (lost_q != '0 || depth_q >= DW'(STACK_FRAMES)) begin
            lost_d   = lost_inc;
            res_body = mk_out(ST_OVERFLOW, 1'b1, 8'(sl_c), row_c);
          end else begin
            fr_we          = 1'b1;
            fr_addr        = FW'(depth_q);
            fr_wdata.slot  = sl_c;
            fr_wdata.start = cur_q.timestamp;
            fr_wdata.child = '0;
            depth_d        = depth_q + DW'(1);
            res_body       = mk_out(ST_OK, 1'b1, 8'(sl_c), row_c);
          end
        end
      end
      // Top frame in hand: work out elapsed and own time, fetch its row
      S_X_FRAME: begin
        elapsed_d = cur_q.timestamp - fr_rd_q.start;
        own_d     = cur_q.timestamp - fr_rd_q.start - fr_rd_q.child;
        slot_d    = fr_rd_q.slot;
        tab_re    = 1'b1;
        tab_addr  = fr_rd_q.slot;
        state_d   = S_X_TABLE;
      end
      S_X_TABLE: begin
        row_c.total = tab_rd_q.total + elapsed_q;
        row_c.net   = tab_rd_q.net + own_q;
        if (own_q < tab_rd_q.min) row_c.min = own_q;
        if (own_q > tab_rd_q.max) row_c.max = own_q;
        tab_we    = 1'b1;
        tab_addr  = slot_q;
        tab_wdata = row_c;
        depth_d   = depth_q - DW'(1);
        res_load  = 1'b1;
        res_body  = mk_out(ST_OK, 1'b1, 8'(slot_q), row_c);
        if (depth_q > DW'(1)) begin
          fr_re   = 1'b1;
          fr_addr = FW'(depth_q - DW'(2));
          state_d = S_X_PARENT;
        end else begin
          state_d = S_IDLE;
        end
      end
      // Charge the elapsed time to the parent frame
      S_X_PARENT: begin
        fr_we          = 1'b1;
        fr_addr        = FW'(depth_q - DW'(1));
        fr_wdata.child = fr_rd_q.child + elapsed_q;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result word: body plus the counters after the transaction
  always_comb begin
    res_next              = res_body;
    res_next.depth        = 7'(depth_d);
    res_next.entries_used = 9'(used_d);
  end

  // Table and frame memories with registered read data
  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_addr] <= tab_wdata;
    if (tab_re) tab_rd_q <= tab_mem[tab_addr];
    if (fr_we) fr_mem[fr_addr] <= fr_wdata;
    if (fr_re) fr_rd_q <= fr_mem[fr_addr];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    scan_q    <= scan_d;
    slot_q    <= slot_d;
    hit_q     <= hit_d;
    elapsed_q <= elapsed_d;
    own_q     <= own_d;
    if (res_load) begin
      res_q <= res_next;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      depth_q     <= '0;
      lost_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      depth_q <= depth_d;
      lost_q  <= lost_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !res_valid_q)
    else $error("result register overwritten");
  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_FRAMES))
    else $error("stack depth beyond capacity");
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(TABLE_ENTRIES))
    else $error("table use beyond capacity");
  a_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_we && state_q == S_ENT_UPD) |-> lost_q == '0)
    else $error("frame pushed while frames are lost");

endmodule

// ===== rtl/call_stack_profiler.sv =====
// Top level of the call stack profiler: front end and back end joined by the
// operation queue. Depends on csp_pkg, csp_front and csp_back.
//
//   channel   handshake          payload       accepted when
//   input     push / full        in_i          push && !full
//   result    empty / pop        res_o         pop && !empty
//   config    cfg_we_i           cfg_wdata_i   cfg_we_i
//
// Back end steps: clear, ignored events, a bad read index, and an exit that is absorbed or
// underflows are answered straight from the idle state; a valid read first fetches its row;
// any other exit reads the top frame, then updates the row and, with a parent, its frame;
// an entry walks the single table memory port one entry a cycle to find its id, then updates.
// Reset clears counters, queue and result valid flag, but not the table, stack memories or
// result data. Input keeps flowing into the two-entry queue while a result waits.
`timescale 1ns / 1ps

module call_stack_profiler #(
  parameter int TABLE_ENTRIES = 256,
  parameter int STACK_FRAMES  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  csp_pkg::csp_in_t  in_i,
  output logic              empty,
  input  logic              pop,
  output csp_pkg::csp_out_t res_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);
  import csp_pkg::*;

  logic    q_valid, q_pop, res_valid;
  csp_op_t q_item;

  assign empty = !res_valid;

  csp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  csp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .STACK_FRAMES  (STACK_FRAMES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_o       (res_o),
    .res_valid_o (res_valid),
    .res_pop_i   (pop && res_valid)
  );

endmodule

// ===== bench/call_stack_profiler_test.sv =====
// Self-checking testbench of the call stack profiler: nested entry/exit traffic,
// reads and clears, checked against a built-in statistics predictor.
// Depends on csp_pkg and call_stack_profiler.
`timescale 1ns / 1ps

class profile_scoreboard;
  logic [31:0] ids[256], counts[256], totals[256], nets[256], mins[256], maxs[256];
  logic [8:0]  used;
  logic [7:0]  fslot[64];
  logic [31:0] fstart[64], fchild[64];
  logic [6:0]  depth;
  logic [15:0] lost;
  bit          enabled;
  csp_pkg::csp_out_t awaited[$];
  int          errors;

  function new();
    used = 0; depth = 0; lost = 0; enabled = 0; errors = 0;
  endfunction

  function csp_pkg::csp_out_t row(logic [2:0] st, bit has, logic [7:0] s);
    csp_pkg::csp_out_t r;
    r = '0;
    r.status = st;
    if (has) begin
      r.slot = s; r.id_out = ids[s]; r.call_count = counts[s];
      r.total_time = totals[s]; r.net_time = nets[s];
      r.min_time = mins[s]; r.max_time = maxs[s];
    end
    r.depth = depth;
    r.entries_used = used;
    return r;
  endfunction

  function void lose();
    if (lost != 16'hFFFF) lost++;
  endfunction

  // Predict the result of one accepted transaction
  function void note(csp_pkg::csp_in_t t);
    int s;
    logic [31:0] el, own;
    s = -1;
    case (t.cmd)
      csp_pkg::CMD_ENTRY: begin
        if (!enabled) begin
          awaited.push_back(row(csp_pkg::ST_DISABLED, 0, 0));
          return;
        end
        for (int i = 0; i < used; i++)
          if (s < 0 && ids[i] == t.function_id) s = i;
        if (s < 0) begin
          if (used >= 256) begin
            lose();
            awaited.push_back(row(csp_pkg::ST_FULL, 0, 0));
            return;
          end
          s = used; used++;
          ids[s] = t.function_id; counts[s] = 0; totals[s] = 0; nets[s] = 0;
          mins[s] = csp_pkg::NONE_MIN; maxs[s] = 0;
        end
        counts[s] += 1;
        if (lost != 0 || depth >= 64) begin
          lose();
          awaited.push_back(row(csp_pkg::ST_OVERFLOW, 1, 8'(s)));
          return;
        end
        fslot[depth] = 8'(s); fstart[depth] = t.timestamp; fchild[depth] = 0;
        depth++;
        awaited.push_back(row(csp_pkg::ST_OK, 1, 8'(s)));
      end
      csp_pkg::CMD_EXIT: begin
        if (!enabled) awaited.push_back(row(csp_pkg::ST_DISABLED, 0, 0));
        else if (lost != 0) begin
          lost--;
          awaited.push_back(row(csp_pkg::ST_OVERFLOW, 0, 0));
        end else if (depth == 0) awaited.push_back(row(csp_pkg::ST_UNDERFLOW, 0, 0));
        else begin
          depth--;
          s = fslot[depth];
          el = t.timestamp - fstart[depth];
          own = el - fchild[depth];
          totals[s] += el; nets[s] += own;
          if (own < mins[s]) mins[s] = own;
          if (own > maxs[s]) maxs[s] = own;
          if (depth > 0) fchild[depth - 1] += el;
          awaited.push_back(row(csp_pkg::ST_OK, 1, 8'(s)));
        end
      end
      csp_pkg::CMD_READ: begin
        if (t.entry_index >= used) awaited.push_back(row(csp_pkg::ST_BAD_INDEX, 0, 0));
        else awaited.push_back(row(csp_pkg::ST_OK, 1, t.entry_index));
      end
      default: begin
        used = 0; depth = 0; lost = 0;
        awaited.push_back(row(csp_pkg::ST_OK, 0, 0));
      end
    endcase
  endfunction

  function void field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %h got %h", $time, name, e, a);
      errors++;
    end
  endfunction

  // Compare one accepted result against the oldest prediction
  function void check(csp_pkg::csp_out_t a);
    csp_pkg::csp_out_t e;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result, expected none got %p", $time, a);
      errors++;
      return;
    end
    e = awaited.pop_front();
    field("status", e.status, a.status);
    field("slot", e.slot, a.slot);
    field("id_out", e.id_out, a.id_out);
    field("call_count", e.call_count, a.call_count);
    field("total_time", e.total_time, a.total_time);
    field("net_time", e.net_time, a.net_time);
    field("min_time", e.min_time, a.min_time);
    field("max_time", e.max_time, a.max_time);
    field("depth", e.depth, a.depth);
    field("entries_used", e.entries_used, a.entries_used);
  endfunction
endclass

module call_stack_profiler_test;
  import csp_pkg::*;

  localparam int LIMIT = 2000000;

  logic      clk_i, rst_ni, push, full, empty, pop, cfg_we_i, cfg_wdata_i;
  csp_in_t   in_i;
  csp_out_t  res_o;

  profile_scoreboard board;
  int        cycles;
  int        send_idle, recv_idle;   // idle percentages
  int        hold_left;
  int        nest;                   // frames opened by the generator
  logic [31:0] now_ts;
  logic [31:0] id_pool[8];

  call_stack_profiler dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_i(in_i),
    .empty(empty), .pop(pop), .res_o(res_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: check, then decide whether to pop next cycle
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) board.check(res_o);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(csp_in_t t);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= t;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note(t);
  endtask

  task automatic op(logic [1:0] c, logic [31:0] id, logic [7:0] idx);
    csp_in_t t;
    now_ts = now_ts + $urandom_range(40);
    t.cmd = c; t.function_id = id; t.timestamp = now_ts; t.entry_index = idx;
    send(t);
  endtask

  // Drain, then write the enable register while the block is idle
  task automatic set_enable(bit v);
    push <= 1'b0;
    @(posedge clk_i);
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.enabled = v;
  endtask

  // One random transaction, mostly well-nested calls over a small id pool
  task automatic random_op();
    int r;
    logic [31:0] id;
    r = $urandom_range(99);
    if (r < 45 || (r < 85 && nest == 0 && $urandom_range(3) != 0)) begin
      id = ($urandom_range(19) == 0) ? $urandom() : id_pool[$urandom_range(7)];
      op(CMD_ENTRY, id, 8'($urandom()));
      nest++;
    end else if (r < 85) begin
      op(CMD_EXIT, $urandom(), 8'($urandom()));
      if (nest > 0) nest--;
    end else if (r < 97) begin
      op(CMD_READ, $urandom(),
         ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(9)));
    end else begin
      op(CMD_CLEAR, $urandom(), 8'($urandom()));
      nest = 0;
    end
  endtask

  initial begin
    board = new();
    cycles = 0; hold_left = 0; send_idle = 0; recv_idle = 0; nest = 0;
    now_ts = 32'hFFFF_FF00;   // wraps early
    push = 0; pop = 0; cfg_we_i = 0; cfg_wdata_i = 0; in_i = '0;
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Disabled: entry and exit ignored; read and clear still work
    op(CMD_ENTRY, 32'hFFFF_FFFF, 8'hFF);
    op(CMD_EXIT, 32'h0, 8'h0);
    op(CMD_READ, 32'h0, 8'h00);
    op(CMD_CLEAR, 32'h0, 8'h0);

    set_enable(1);
    op(CMD_EXIT, 32'h0, 8'h0);                 // underflow
    op(CMD_ENTRY, 32'h0, 8'h0);
    op(CMD_ENTRY, 32'hFFFF_FFFF, 8'h0);
    op(CMD_ENTRY, 32'h0, 8'h0);                // recursion, same entry
    op(CMD_EXIT, 32'h0, 8'h0);
    op(CMD_EXIT, 32'h0, 8'h0);
    op(CMD_EXIT, 32'h0, 8'h0);                 // outermost exit
    op(CMD_READ, 32'h0, 8'h01);
    op(CMD_READ, 32'h0, 8'h02);                // bad index
    op(CMD_READ, 32'h0, 8'hFF);

    // Stack overflow and lost-frame exits
    for (int i = 0; i < 66; i++) op(CMD_ENTRY, i % 3, 8'h0);
    for (int i = 0; i < 67; i++) op(CMD_EXIT, 32'h0, 8'h0);
    op(CMD_CLEAR, 32'h0, 8'h0);

    // Table full, then exits absorb the lost frames
    for (int i = 0; i < 258; i++) op(CMD_ENTRY, 32'hA5A5_0000 + i, 8'h0);
    op(CMD_READ, 32'h0, 8'hFF);
    for (int i = 0; i < 70; i++) op(CMD_EXIT, 32'h0, 8'h0);
    op(CMD_CLEAR, 32'h0, 8'h0);

    // Random phases across idling patterns and enable settings
    for (int ph = 0; ph < 5; ph++) begin
      set_enable(ph != 3);
      for (int k = 0; k < 8; k++) id_pool[k] = $urandom();
      id_pool[0] = 32'h0; id_pool[1] = 32'hFFFF_FFFF;
      case (ph)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 49; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 49; end
        3: begin send_idle = 24; recv_idle = 24; end
        default: begin send_idle = 24; recv_idle = 24; end
      endcase
      if (ph == 4) hold_left = 400;   // long receiver stall fills the block
      nest = 0;
      for (int n = 0; n < 125; n++) random_op();
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
